### hdl/hvd_pkg.sv
package hvd_pkg;

	// Widths of the CORDIC datapath.
	localparam int XW = 33;
	localparam int ZW = 34;
	localparam int RW = 34;
	localparam int SQ_STAGES = 31;
	localparam int SQ_NW = 2 * SQ_STAGES;
	localparam int RADIUS_W = 13;
	localparam int DIST_W = 23;
	localparam int ANGLE_FRAC_BITS_DEF = 16;
	localparam int CORDIC_STAGES_DEF = 20;

	// Angles are degrees times 2^24.
	localparam logic signed [63:0] DEG_HALF_TURN = 64'sd3019898880;
	localparam logic signed [63:0] DEG_FULL_TURN = 64'sd6039797760;
	localparam logic signed [63:0] DEG_QUARTER = 64'sd1509949440;
	localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(64'sd652032874);
	localparam logic [26:0] RAD_PER_DEG_Q32 = 27'd74961321;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [DIST_W-1:0] OUT_MAX = {DIST_W{1'b1}};
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 13'd6371;

	typedef logic signed [XW-1:0] xy_t;
	typedef logic signed [ZW-1:0] ang_t;

	function automatic logic [31:0] atan_deg24(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0: v = 32'd754974720;
			5'd1: v = 32'd445687602;
			5'd2: v = 32'd235489088;
			5'd3: v = 32'd119537938;
			5'd4: v = 32'd60000934;
			5'd5: v = 32'd30029717;
			5'd6: v = 32'd15018523;
			5'd7: v = 32'd7509720;
			5'd8: v = 32'd3754917;
			5'd9: v = 32'd1877466;
			5'd10: v = 32'd938734;
			5'd11: v = 32'd469367;
			5'd12: v = 32'd234684;
			5'd13: v = 32'd117342;
			5'd14: v = 32'd58671;
			5'd15: v = 32'd29335;
			5'd16: v = 32'd14668;
			5'd17: v = 32'd7334;
			5'd18: v = 32'd3667;
			5'd19: v = 32'd1833;
			5'd20: v = 32'd917;
			5'd21: v = 32'd458;
			5'd22: v = 32'd229;
			5'd23: v = 32'd115;
			5'd24: v = 32'd57;
			5'd25: v = 32'd29;
			5'd26: v = 32'd14;
			5'd27: v = 32'd7;
			5'd28: v = 32'd4;
			5'd29: v = 32'd2;
			5'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

### hdl/hvd_wrap.sv
module hvd_wrap #(
	parameter int ANG_W = 35
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [ANG_W-1:0]  ang,
	output hvd_pkg::ang_t            z,
	output logic                     flip
);

	localparam int K = (ANG_W > 32) ? ANG_W - 32 : 0;
	localparam int VW = ((ANG_W > 32) ? ANG_W : 32) + 3;
	localparam logic signed [VW-1:0] HALF = VW'(hvd_pkg::DEG_HALF_TURN);
	localparam logic signed [VW-1:0] QUARTER = VW'(hvd_pkg::DEG_QUARTER);
	localparam logic signed [VW-1:0] FULL_K = VW'(hvd_pkg::DEG_FULL_TURN <<< K);

	logic signed [VW-1:0] v_s [K+2];
	logic signed [VW-1:0] pre;
	logic signed [VW-1:0] r;

	// Offset by half a turn so that the reduction works on a non-negative value.
	always_comb begin
		pre = VW'(ang) + HALF;
		if (pre < 0) begin
			pre = pre + FULL_K;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s[0] <= pre;
		end
	end

	for (genvar j = 0; j <= K; j++) begin : g_red
		localparam logic signed [VW-1:0] STEP = VW'(hvd_pkg::DEG_FULL_TURN <<< (K - j));
		always_ff @(posedge clk) begin
			if (en) begin
				if (v_s[j] >= STEP) begin
					v_s[j+1] <= v_s[j] - STEP;
				end else begin
					v_s[j+1] <= v_s[j];
				end
			end
		end
	end

	assign r = v_s[K+1] - HALF;

	// Fold into the right half plane; the caller negates the CORDIC results.
	always_ff @(posedge clk) begin
		if (en) begin
			if (r > QUARTER) begin
				z <= hvd_pkg::ZW'(r - HALF);
				flip <= 1'b1;
			end else if (r < -QUARTER) begin
				z <= hvd_pkg::ZW'(r + HALF);
				flip <= 1'b1;
			end else begin
				z <= hvd_pkg::ZW'(r);
				flip <= 1'b0;
			end
		end
	end

endmodule

### hdl/hvd_rot_cell.sv
module hvd_rot_cell #(
	parameter int STAGE = 0
) (
	input  logic          clk,
	input  logic          en,
	input  hvd_pkg::xy_t  x_in,
	input  hvd_pkg::xy_t  y_in,
	input  hvd_pkg::ang_t z_in,
	output hvd_pkg::xy_t  x_out,
	output hvd_pkg::ang_t z_out,
	output hvd_pkg::xy_t  y_out
);

	localparam hvd_pkg::ang_t ATAN = hvd_pkg::ZW'(hvd_pkg::atan_deg24(5'(STAGE)));

	hvd_pkg::xy_t dx;
	hvd_pkg::xy_t dy;

	assign dx = y_in >>> STAGE;
	assign dy = x_in >>> STAGE;

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_in >= 0) begin
				x_out <= x_in - dx;
				y_out <= y_in + dy;
				z_out <= z_in - ATAN;
			end else begin
				x_out <= x_in + dx;
				y_out <= y_in - dy;
				z_out <= z_in + ATAN;
			end
		end
	end

endmodule

### hdl/hvd_vec_cell.sv
module hvd_vec_cell #(
	parameter int STAGE = 0
) (
	input  logic          clk,
	input  logic          en,
	input  hvd_pkg::xy_t  x_in,
	input  hvd_pkg::xy_t  y_in,
	input  hvd_pkg::ang_t z_in,
	output hvd_pkg::xy_t  x_out,
	output hvd_pkg::xy_t  y_out,
	output hvd_pkg::ang_t z_out
);

	localparam hvd_pkg::ang_t ATAN = hvd_pkg::ZW'(hvd_pkg::atan_deg24(5'(STAGE)));

	hvd_pkg::xy_t dx;
	hvd_pkg::xy_t dy;

	assign dx = y_in >>> STAGE;
	assign dy = x_in >>> STAGE;

	// Drive y towards zero, accumulating the angle turned through.
	always_ff @(posedge clk) begin
		if (en) begin
			if (y_in > 0) begin
				x_out <= x_in + dx;
				y_out <= y_in - dy;
				z_out <= z_in + ATAN;
			end else begin
				x_out <= x_in - dx;
				y_out <= y_in + dy;
				z_out <= z_in - ATAN;
			end
		end
	end

endmodule

### hdl/hvd_sqrt_cell.sv
module hvd_sqrt_cell (
	input  logic                          clk,
	input  logic                          en,
	input  logic [hvd_pkg::SQ_NW-1:0]     n_in,
	input  logic [hvd_pkg::SQ_STAGES-1:0] r_in,
	input  logic [hvd_pkg::RW-1:0]        rem_in,
	output logic [hvd_pkg::SQ_NW-1:0]     n_out,
	output logic [hvd_pkg::SQ_STAGES-1:0] r_out,
	output logic [hvd_pkg::RW-1:0]        rem_out
);

	logic [hvd_pkg::RW-1:0] rem_w;
	logic [hvd_pkg::RW-1:0] trial;

	// One root bit per cell: bring down the next two radicand bits and try 4r+1.
	assign rem_w = {rem_in[hvd_pkg::RW-3:0], n_in[hvd_pkg::SQ_NW-1 -: 2]};
	assign trial = {1'b0, r_in, 2'b01};

	always_ff @(posedge clk) begin
		if (en) begin
			n_out <= {n_in[hvd_pkg::SQ_NW-3:0], 2'b00};
			if (rem_w >= trial) begin
				rem_out <= rem_w - trial;
				r_out <= {r_in[hvd_pkg::SQ_STAGES-2:0], 1'b1};
			end else begin
				rem_out <= rem_w;
				r_out <= {r_in[hvd_pkg::SQ_STAGES-2:0], 1'b0};
			end
		end
	end

endmodule

### hdl/haversine_distance.sv
// Great-circle distance between two points by the haversine formula.
// Input stream: one transaction carries both points as latitude and longitude
// in signed degrees with ANGLE_FRAC_BITS fraction bits. Output stream: one
// transaction per input, the distance in kilometres with 8 fraction bits,
// saturated at the top of its 23-bit range. The sphere radius in whole
// kilometres is to be written through radius_we/radius_wdata only while the
// block is idle (the block itself does not enforce this); it resets to 6371.
// Throughput is one transaction per cycle while the output is not stalled.
// From input acceptance to output, a transaction passes through the input
// stage, the angle reduction, the rotation CORDIC, three multiply stages, a
// 31-cell square root, the vectoring CORDIC and two scaling multiplies, each a
// register stage.
// The whole pipeline advances together; when the output is valid and not
// taken, every stage holds and s_axis_tready drops in the same cycle.
// Reset clears every valid bit and restores the radius; the pipeline is empty
// afterwards.
module haversine_distance #(
	parameter int ANGLE_FRAC_BITS = hvd_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES = hvd_pkg::CORDIC_STAGES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// first_latitude, first_longitude, second_latitude, second_longitude, zero pad
	input  logic [103:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// distance_km, zero pad
	output logic [23:0]  m_axis_tdata,
	input  logic         radius_we,
	input  logic [hvd_pkg::RADIUS_W-1:0] radius_wdata
);

	localparam int SH = 24 - ANGLE_FRAC_BITS;
	localparam int ANG_W = 51 - ANGLE_FRAC_BITS;
	localparam int K = (ANG_W > 32) ? ANG_W - 32 : 0;
	localparam int N = CORDIC_STAGES;
	localparam int Q = hvd_pkg::SQ_STAGES;
	localparam int LAT = 1 + (K + 3) + N + 3 + Q + N + 2;
	localparam int V_WRAP = K + 3;
	localparam int V_A = K + 3 + N + 3;

	logic                          en;
	logic [LAT-1:0]                valid_s;
	logic [hvd_pkg::RADIUS_W-1:0]  radius_q;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = valid_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[LAT-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= hvd_pkg::RADIUS_RESET;
		end else if (radius_we) begin
			radius_q <= radius_wdata;
		end
	end

	// Input stage: scale to degrees * 2^24 and form the half differences.
	logic signed [ANG_W-1:0] lat1;
	logic signed [ANG_W-1:0] lon1;
	logic signed [ANG_W-1:0] lat2;
	logic signed [ANG_W-1:0] lon2;
	logic signed [ANG_W-1:0] dlat;
	logic signed [ANG_W-1:0] dlon;
	logic signed [ANG_W-1:0] hlat;
	logic signed [ANG_W-1:0] hlon;
	logic signed [ANG_W-1:0] ang_s1 [4];

	assign lat1 = ANG_W'($signed(s_axis_tdata[23:0]));
	assign lon1 = ANG_W'($signed(s_axis_tdata[48:24]));
	assign lat2 = ANG_W'($signed(s_axis_tdata[72:49]));
	assign lon2 = ANG_W'($signed(s_axis_tdata[97:73]));
	assign dlat = (lat2 - lat1) <<< SH;
	assign dlon = (lon2 - lon1) <<< SH;
	// Halving truncates towards zero.
	assign hlat = (dlat + $signed(ANG_W'(dlat < 0))) >>> 1;
	assign hlon = (dlon + $signed(ANG_W'(dlon < 0))) >>> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1[0] <= hlat;
			ang_s1[1] <= hlon;
			ang_s1[2] <= lat1 <<< SH;
			ang_s1[3] <= lat2 <<< SH;
		end
	end

	// Four lanes of angle reduction and rotation CORDIC.
	hvd_pkg::xy_t  rx [4][N+1];
	hvd_pkg::xy_t  ry [4][N+1];
	hvd_pkg::ang_t rz [4][N+1];
	logic          flip_s [4][N+1];

	for (genvar l = 0; l < 4; l++) begin : g_lane
		hvd_wrap #(.ANG_W(ANG_W)) u_wrap (
			.clk  (clk),
			.en   (en),
			.ang  (ang_s1[l]),
			.z    (rz[l][0]),
			.flip (flip_s[l][0])
		);
		assign rx[l][0] = hvd_pkg::CORDIC_GAIN;
		assign ry[l][0] = '0;
		for (genvar i = 0; i < N; i++) begin : g_rot
			hvd_rot_cell #(.STAGE(i)) u_cell (
				.clk   (clk),
				.en    (en),
				.x_in  (rx[l][i]),
				.y_in  (ry[l][i]),
				.z_in  (rz[l][i]),
				.x_out (rx[l][i+1]),
				.z_out (rz[l][i+1]),
				.y_out (ry[l][i+1])
			);
			always_ff @(posedge clk) begin
				if (en) begin
					flip_s[l][i+1] <= flip_s[l][i];
				end
			end
		end
	end

	// Products of the haversine terms, Q30 throughout.
	logic signed [31:0] s1;
	logic signed [31:0] s2;
	logic signed [31:0] c1;
	logic signed [31:0] c2;
	logic signed [63:0] p_s1sq;
	logic signed [63:0] p_s2sq;
	logic signed [63:0] p_cc;
	logic signed [32:0] s1sq_s1;
	logic signed [32:0] s2sq_s1;
	logic signed [32:0] cc_s1;
	logic signed [32:0] s1sq_s2;
	logic signed [32:0] prod_s2;
	logic signed [63:0] p_2;
	logic signed [33:0] a_sum;
	logic [30:0]        a_s3;
	logic [30:0]        b_s3;

	assign s1 = flip_s[0][N] ? -ry[0][N][31:0] : ry[0][N][31:0];
	assign s2 = flip_s[1][N] ? -ry[1][N][31:0] : ry[1][N][31:0];
	assign c1 = flip_s[2][N] ? -rx[2][N][31:0] : rx[2][N][31:0];
	assign c2 = flip_s[3][N] ? -rx[3][N][31:0] : rx[3][N][31:0];
	assign p_s1sq = s1 * s1;
	assign p_s2sq = s2 * s2;
	assign p_cc = c1 * c2;
	// The cosine product may be negative, so both factors stay signed.
	assign p_2 = s2sq_s1 * cc_s1;
	assign a_sum = 34'(s1sq_s2) + 34'(prod_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			s1sq_s1 <= 33'(p_s1sq >>> 30);
			s2sq_s1 <= 33'(p_s2sq >>> 30);
			cc_s1 <= 33'(p_cc >>> 30);
			s1sq_s2 <= s1sq_s1;
			prod_s2 <= 33'(p_2 >>> 30);
			if (a_sum < 0) begin
				a_s3 <= '0;
				b_s3 <= hvd_pkg::Q30_ONE;
			end else if (a_sum > 34'(hvd_pkg::Q30_ONE)) begin
				a_s3 <= hvd_pkg::Q30_ONE;
				b_s3 <= '0;
			end else begin
				a_s3 <= a_sum[30:0];
				b_s3 <= hvd_pkg::Q30_ONE - a_sum[30:0];
			end
		end
	end

	// Square roots of a and 1-a, one root bit per cell.
	logic [hvd_pkg::SQ_NW-1:0] sq_n   [2][Q+1];
	logic [Q-1:0]              sq_r   [2][Q+1];
	logic [hvd_pkg::RW-1:0]    sq_rem [2][Q+1];

	assign sq_n[0][0] = {1'b0, a_s3, 30'b0};
	assign sq_n[1][0] = {1'b0, b_s3, 30'b0};

	for (genvar m = 0; m < 2; m++) begin : g_root
		assign sq_r[m][0] = '0;
		assign sq_rem[m][0] = '0;
		for (genvar i = 0; i < Q; i++) begin : g_bit
			hvd_sqrt_cell u_cell (
				.clk     (clk),
				.en      (en),
				.n_in    (sq_n[m][i]),
				.r_in    (sq_r[m][i]),
				.rem_in  (sq_rem[m][i]),
				.n_out   (sq_n[m][i+1]),
				.r_out   (sq_r[m][i+1]),
				.rem_out (sq_rem[m][i+1])
			);
		end
	end

	// asin(sqrt(a)) as atan2(sqrt(a), sqrt(1-a)).
	hvd_pkg::xy_t  vx [N+1];
	hvd_pkg::xy_t  vy [N+1];
	hvd_pkg::ang_t vz [N+1];

	assign vx[0] = hvd_pkg::XW'(sq_r[1][Q]);
	assign vy[0] = hvd_pkg::XW'(sq_r[0][Q]);
	assign vz[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_vec
		hvd_vec_cell #(.STAGE(i)) u_cell (
			.clk   (clk),
			.en    (en),
			.x_in  (vx[i]),
			.y_in  (vy[i]),
			.z_in  (vz[i]),
			.x_out (vx[i+1]),
			.y_out (vy[i+1]),
			.z_out (vz[i+1])
		);
	end

	// Degrees to radians, then scale by twice the radius with rounding.
	logic [30:0]                th;
	logic [57:0]                p_rad;
	logic [33:0]                rad_s1;
	logic [48:0]                p_dist;
	logic [24:0]                dist_round;
	logic [hvd_pkg::DIST_W-1:0] dist_s2;

	assign th = (vz[N] < 0) ? '0 : vz[N][30:0];
	assign p_rad = 58'(th) * 58'(hvd_pkg::RAD_PER_DEG_Q32);
	assign p_dist = 49'(radius_q) * 49'({rad_s1, 1'b0}) + 49'(1 << 23);
	assign dist_round = p_dist[48:24];

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= p_rad[57:24];
			if (dist_round > 25'(hvd_pkg::OUT_MAX)) begin
				dist_s2 <= hvd_pkg::OUT_MAX;
			end else begin
				dist_s2 <= dist_round[hvd_pkg::DIST_W-1:0];
			end
		end
	end

	assign m_axis_tdata = {1'b0, dist_s2};

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while output stalled");

	a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s[0])
		else $error("accepted transaction not captured");

	a_fold_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[V_WRAP] |-> (rz[1][0] <= hvd_pkg::ZW'(hvd_pkg::DEG_QUARTER)
			&& rz[1][0] >= -hvd_pkg::ZW'(hvd_pkg::DEG_QUARTER)))
		else $error("reduced angle outside quarter turn");

	a_clamp_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[V_A] |-> (32'(a_s3) + 32'(b_s3) == 32'(hvd_pkg::Q30_ONE)))
		else $error("root operands do not sum to one");

endmodule
